// ----- design/mpg_pkg.sv -----
// ----------------------------------------------------------------------------
// mpg_pkg
// Shared types, codes and default sizes of the multichannel pwm generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpg_pkg;

   localparam int DEF_NUM_CHANNELS  = 6;
   localparam int DEF_COUNT_WIDTH   = 16;
   localparam int DEF_DIVIDER_WIDTH = 11;

   localparam int KIND_WIDTH     = 2;
   localparam int CHANNEL_WIDTH  = 3;
   localparam int FIELD_CNT_WIDTH = 16;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_TICK   = 2'd0,
      KIND_SETUP  = 2'd1,
      KIND_ENABLE = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      REG_GLOBAL_ENABLE = 1'b0,
      REG_CLOCK_DIVIDER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic global_enable;
      logic step;
      logic setup_write;
      logic enable_write;
   } chan_ctl_type;

   typedef struct packed {
      logic invert;
      logic enable;
      logic level_next;
   } chan_stat_type;

endpackage

`default_nettype wire

// ----- design/mpg_req_if.sv -----
// ----------------------------------------------------------------------------
// mpg_req_if
// Request channel: tick, channel setup, enable write or status read words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpg_req_if;
   logic                                valid;
   logic                                ready;
   logic [mpg_pkg::KIND_WIDTH-1:0]      kind;
   logic [mpg_pkg::CHANNEL_WIDTH-1:0]   channel;
   logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] high_count;
   logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] low_count;
   logic                                invert;
   logic                                enable;

   modport source (
      output valid, kind, channel, high_count, low_count, invert, enable,
      input  ready
   );
   modport sink (
      input  valid, kind, channel, high_count, low_count, invert, enable,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/mpg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mpg_rsp_if
// Response channel: pin levels and status read-back words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpg_rsp_if #(
   parameter int NUM_CHANNELS = mpg_pkg::DEF_NUM_CHANNELS
);
   logic                                valid;
   logic                                ready;
   logic [NUM_CHANNELS-1:0]             levels;
   logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] read_high_count;
   logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] read_low_count;
   logic                                read_invert;
   logic                                read_enable;

   modport source (
      output valid, levels, read_high_count, read_low_count, read_invert,
             read_enable,
      input  ready
   );
   modport sink (
      input  valid, levels, read_high_count, read_low_count, read_invert,
             read_enable,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/multichannel_pwm_generator.sv -----
// ----------------------------------------------------------------------------
// multichannel_pwm_generator
// Pwm peripheral with a shared prescaler and per-channel high/low counters.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_port  in         kind, channel, high_count, low_count, invert, enable
//  rsp_port  out        levels, read_high_count, read_low_count, read_invert,
//                       read_enable
//  csr_*     in         write enable, register index, write data
//
//  one word per clock while req_port.ready is high; each word's result is registered
//  prescaler and channel counters update at the edge a word is accepted
//  a two-entry output buffer (main and skid entries) keeps req_port.ready high
//  while the skid entry is empty; ready drops only while both entries hold words
//  synchronous reset clears all channel settings and global_enable, and sets clock_divider to 1 in the csr registers
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pwm_generator #(
   parameter int NUM_CHANNELS  = mpg_pkg::DEF_NUM_CHANNELS,
   parameter int COUNT_WIDTH   = mpg_pkg::DEF_COUNT_WIDTH,
   parameter int DIVIDER_WIDTH = mpg_pkg::DEF_DIVIDER_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   mpg_req_if.sink                        req_port,
   mpg_rsp_if.source                      rsp_port,
   input  wire logic                      csr_write_enable,
   input  wire mpg_pkg::csr_index_type    csr_index,
   input  wire logic [DIVIDER_WIDTH-1:0]  csr_data
);

   typedef struct packed {
      logic [NUM_CHANNELS-1:0]             levels;
      logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] read_high_count;
      logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] read_low_count;
      logic                                read_invert;
      logic                                read_enable;
   } rsp_word_type;

   logic                     global_enable_ff;
   logic [DIVIDER_WIDTH-1:0] clock_divider_ff;
   logic [DIVIDER_WIDTH-1:0] prescale_ff, prescale_in;

   logic                     accept;
   logic                     take;
   logic                     tick_run;
   logic                     wrap;
   logic [DIVIDER_WIDTH-1:0] prescale_next;
   logic [DIVIDER_WIDTH-1:0] div_eff;

   mpg_pkg::chan_ctl_type    ctl   [NUM_CHANNELS];
   mpg_pkg::chan_stat_type   stat  [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]   high_s[NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]   low_s [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]  sel;

   rsp_word_type             result;
   rsp_word_type             main_ff, main_in;
   rsp_word_type             skid_ff, skid_in;
   logic                     main_valid_ff, main_valid_in;
   logic                     skid_valid_ff, skid_valid_in;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         global_enable_ff <= 1'b0;
         clock_divider_ff <= DIVIDER_WIDTH'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mpg_pkg::REG_GLOBAL_ENABLE: global_enable_ff <= csr_data[0];
            mpg_pkg::REG_CLOCK_DIVIDER: clock_divider_ff <= csr_data;
            default:                    global_enable_ff <= global_enable_ff;
         endcase
      end
   end

   assign req_port.ready = !skid_valid_ff;
   assign accept         = req_port.valid && req_port.ready;
   assign take           = main_valid_ff && rsp_port.ready;

   // prescaler
   assign tick_run      = accept && (req_port.kind == mpg_pkg::KIND_TICK) && global_enable_ff;
   assign prescale_next = prescale_ff + DIVIDER_WIDTH'(1);
   assign div_eff       = (clock_divider_ff == '0) ? DIVIDER_WIDTH'(1) : clock_divider_ff;
   assign wrap          = (prescale_next >= div_eff) || (prescale_next == '0);
   assign prescale_in   = tick_run ? (wrap ? '0 : prescale_next) : prescale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
      end else begin
         prescale_ff <= prescale_in;
      end
   end

   // channels
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      assign sel[c]                = (int'(req_port.channel) == c);
      assign ctl[c].global_enable  = global_enable_ff;
      assign ctl[c].step           = tick_run && wrap;
      assign ctl[c].setup_write    = accept && sel[c] && (req_port.kind == mpg_pkg::KIND_SETUP);
      assign ctl[c].enable_write   = accept && sel[c] && (req_port.kind == mpg_pkg::KIND_ENABLE);

      mpg_channel #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl[c]),
         .wr_high_count (req_port.high_count),
         .wr_low_count  (req_port.low_count),
         .wr_invert     (req_port.invert),
         .wr_enable     (req_port.enable),
         .high_setting  (high_s[c]),
         .low_setting   (low_s[c]),
         .stat          (stat[c])
      );
   end

   // result word
   always_comb begin
      result = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         result.levels[c] = stat[c].level_next;
         if (sel[c] && req_port.kind == mpg_pkg::KIND_READ) begin
            result.read_high_count = result.read_high_count
                                   | mpg_pkg::FIELD_CNT_WIDTH'(high_s[c]);
            result.read_low_count  = result.read_low_count
                                   | mpg_pkg::FIELD_CNT_WIDTH'(low_s[c]);
            result.read_invert     = result.read_invert | stat[c].invert;
            result.read_enable     = result.read_enable | stat[c].enable;
         end
      end
   end

   // output buffer
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || take) begin
         main_valid_in = accept || skid_valid_ff;
         skid_valid_in = 1'b0;
         main_in       = skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_port.valid           = main_valid_ff;
   assign rsp_port.levels          = main_ff.levels;
   assign rsp_port.read_high_count = main_ff.read_high_count;
   assign rsp_port.read_low_count  = main_ff.read_low_count;
   assign rsp_port.read_invert     = main_ff.read_invert;
   assign rsp_port.read_enable     = main_ff.read_enable;

endmodule

`default_nettype wire

// ----- design/mpg_channel.sv -----
// ----------------------------------------------------------------------------
// mpg_channel
// One pwm channel: settings, high/low phase counter and next pin level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_channel #(
   parameter int COUNT_WIDTH = mpg_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mpg_pkg::chan_ctl_type               ctl,
   input  wire logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] wr_high_count,
   input  wire logic [mpg_pkg::FIELD_CNT_WIDTH-1:0] wr_low_count,
   input  wire logic                                wr_invert,
   input  wire logic                                wr_enable,
   output      logic [COUNT_WIDTH-1:0]              high_setting,
   output      logic [COUNT_WIDTH-1:0]              low_setting,
   output      mpg_pkg::chan_stat_type              stat
);

   logic [COUNT_WIDTH-1:0] phase_ff, phase_in;
   logic                   high_phase_ff, high_phase_in;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic                   invert_ff, invert_in;
   logic                   enable_ff, enable_in;

   always_comb begin
      logic                   hp_v;
      logic [COUNT_WIDTH-1:0] pc_v;
      logic [COUNT_WIDTH-1:0] len_v;
      logic                   raw_v;

      phase_in      = phase_ff;
      high_phase_in = high_phase_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      invert_in     = invert_ff;
      enable_in     = enable_ff;
      hp_v          = high_phase_ff;
      pc_v          = phase_ff;
      len_v         = '0;

      if (ctl.setup_write) begin
         high_in       = COUNT_WIDTH'(wr_high_count);
         low_in        = COUNT_WIDTH'(wr_low_count);
         invert_in     = wr_invert;
         enable_in     = wr_enable;
         phase_in      = '0;
         high_phase_in = 1'b1;
      end else if (ctl.enable_write) begin
         enable_in     = wr_enable;
         phase_in      = '0;
         high_phase_in = 1'b1;
      end else if (ctl.step && enable_ff && (high_ff != '0 || low_ff != '0)) begin
         // skip an empty phase first
         if (hp_v && high_ff == '0) begin
            hp_v = 1'b0;
            pc_v = '0;
         end else if (!hp_v && low_ff == '0) begin
            hp_v = 1'b1;
            pc_v = '0;
         end
         len_v = hp_v ? high_ff : low_ff;
         pc_v  = pc_v + COUNT_WIDTH'(1);
         if (pc_v >= len_v) begin
            pc_v = '0;
            hp_v = !hp_v;
         end
         phase_in      = pc_v;
         high_phase_in = hp_v;
      end

      if (high_in == '0) begin
         raw_v = 1'b0;
      end else if (low_in == '0) begin
         raw_v = 1'b1;
      end else begin
         raw_v = high_phase_in;
      end

      stat.invert     = invert_ff;
      stat.enable     = enable_ff;
      stat.level_next = (ctl.global_enable && enable_in) ? (raw_v ^ invert_in) : invert_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         high_phase_ff <= 1'b1;
         high_ff       <= '0;
         low_ff        <= '0;
         invert_ff     <= 1'b0;
         enable_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         high_phase_ff <= high_phase_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         invert_ff     <= invert_in;
         enable_ff     <= enable_in;
      end
   end

   assign high_setting = high_ff;
   assign low_setting  = low_ff;

endmodule

`default_nettype wire
